### sv/efc_pkg.sv
`timescale 1ns / 1ps

package efc_pkg;

  localparam int NUM_ENCODERS = 6;
  localparam int COUNTER_BITS = 16;
  localparam int KINDS        = 3;
  localparam int NUM_COUNTERS = NUM_ENCODERS * KINDS;
  localparam int ADDR_W       = $clog2(NUM_COUNTERS);

  localparam logic [15:0] WINDOW_LENGTH_RESET = 16'd10000;
  localparam logic [2:0]  FRAME_STATUS_OK     = 3'b100;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_TICK   = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_LINK   = 2'd1,
    ST_PARITY = 2'd2,
    ST_FIELD  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    KIND_LINK   = 2'd0,
    KIND_PARITY = 2'd1,
    KIND_FIELD  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic {
    REG_WINDOW_LENGTH   = 1'b0,
    REG_ERROR_THRESHOLD = 1'b1
  } cfg_reg_t;

  // Counter index for one encoder and one error kind.
  function automatic logic [ADDR_W-1:0] counter_addr(logic [2:0] enc, logic [1:0] kind);
    return ADDR_W'(enc) * ADDR_W'(KINDS) + ADDR_W'(kind);
  endfunction

  // Clamp a counter to the 16-bit read field.
  function automatic logic [15:0] clamp16(logic [COUNTER_BITS-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
  endfunction

endpackage

### sv/efc_if.sv
`timescale 1ns / 1ps

interface efc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [2:0]  encoder_index;
  logic        link_ok;
  logic [17:0] raw_frame;
  logic [1:0]  error_kind;

  modport source (output valid, opcode, encoder_index, link_ok, raw_frame, error_kind,
                  input ready);
  modport sink   (input valid, opcode, encoder_index, link_ok, raw_frame, error_kind,
                  output ready);
endinterface

interface efc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] position;
  logic [1:0]  status;
  logic        alarm;
  logic [15:0] counter_value;

  modport source (output valid, position, status, alarm, counter_value, input ready);
  modport sink   (input valid, position, status, alarm, counter_value, output ready);
endinterface

interface efc_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### sv/encoder_frame_checker_with_error_stats.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake     Payload
// req      in   valid/ready   opcode, encoder_index, link_ok, raw_frame, error_kind
// rsp      out  valid/ready   position, status, alarm, counter_value
// cfg      in   valid/ready   index (0 window_length, 1 error_threshold), data
//
// Counted errors pass S_UPD and in-range reads S_RD before S_DONE; others skip them.
// A tick that ends a window scans all 18 counters through the single counter RAM read
// port, each in S_SCAN_RD then S_SCAN_CMP. req.ready is high only when idle.
// A waiting result holds only the finishing step; req is taken again once it leaves.
// Synchronous reset marks all counters clear through per-counter valid bits; no sweep.

module encoder_frame_checker_with_error_stats
  import efc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  efc_in_if.sink     req,
  efc_out_if.source  rsp,
  efc_cfg_if.sink    cfg
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_RD,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_DONE
  } state_t;

  localparam logic [ADDR_W-1:0]       LAST_ADDR = ADDR_W'(NUM_COUNTERS - 1);
  localparam logic [COUNTER_BITS-1:0] CNT_MAX   = '1;

  state_t                  state;
  logic [ADDR_W-1:0]       addr_q;
  logic [NUM_COUNTERS-1:0] cnt_valid;
  logic [15:0]             window_count;
  logic [15:0]             window_length;
  logic [15:0]             error_threshold;

  logic [15:0] res_position;
  logic [1:0]  res_status;
  logic        res_alarm;
  logic [15:0] res_counter;

  logic        out_valid;
  logic [15:0] out_position;
  logic [1:0]  out_status;
  logic        out_alarm;
  logic [15:0] out_counter;
  logic        load_out;

  logic                    ram_we;
  logic                    ram_re;
  logic [ADDR_W-1:0]       ram_raddr;
  logic [COUNTER_BITS-1:0] ram_wdata;
  logic [COUNTER_BITS-1:0] ram_rdata;
  logic [COUNTER_BITS-1:0] cur;

  logic        accept;
  status_t     chk_status;
  kind_t       chk_kind;
  logic        enc_ok;
  logic [ADDR_W-1:0] acc_addr;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  assign rsp.valid         = out_valid;
  assign rsp.position      = out_position;
  assign rsp.status        = out_status;
  assign rsp.alarm         = out_alarm;
  assign rsp.counter_value = out_counter;

  // Load the output register once it is free.
  assign load_out = (state == S_DONE) && (!out_valid || rsp.ready);

  // Frame check: link first, then parity, then the status field.
  always_comb begin
    enc_ok = (32'(req.encoder_index) < NUM_ENCODERS);
    priority if (!req.link_ok) begin
      chk_status = ST_LINK;
      chk_kind   = KIND_LINK;
    end else if (^req.raw_frame) begin
      chk_status = ST_PARITY;
      chk_kind   = KIND_PARITY;
    end else if (req.raw_frame[5:3] != FRAME_STATUS_OK) begin
      chk_status = ST_FIELD;
      chk_kind   = KIND_FIELD;
    end else begin
      chk_status = ST_OK;
      chk_kind   = KIND_NONE;
    end
    if (opcode_t'(req.opcode) == OP_SAMPLE) begin
      acc_addr = counter_addr(req.encoder_index, chk_kind);
    end else begin
      acc_addr = counter_addr(req.encoder_index, req.error_kind);
    end
  end

  // Never-written or cleared counters read as zero.
  assign cur = cnt_valid[addr_q] ? ram_rdata : '0;

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = acc_addr;
    ram_we    = (state == S_UPD);
    ram_wdata = (cur == CNT_MAX) ? cur : cur + COUNTER_BITS'(1);
    unique case (state)
      S_IDLE: begin
        ram_re = accept;
      end
      S_SCAN_RD: begin
        ram_re    = 1'b1;
        ram_raddr = addr_q;
      end
      S_UPD, S_RD, S_SCAN_CMP, S_DONE: begin
        ram_re = 1'b0;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  efc_ram #(
    .WIDTH(COUNTER_BITS),
    .DEPTH(NUM_COUNTERS)
  ) u_counters (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_q),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      cnt_valid       <= '0;
      window_count    <= '0;
      window_length   <= WINDOW_LENGTH_RESET;
      error_threshold <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        unique case (cfg_reg_t'(cfg.index))
          REG_WINDOW_LENGTH:   window_length   <= cfg.data;
          REG_ERROR_THRESHOLD: error_threshold <= cfg.data;
          default: ;
        endcase
      end

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_position <= (opcode_t'(req.opcode) == OP_SAMPLE && chk_status == ST_OK) ?
                            {req.raw_frame[17:6], 4'b0000} : '0;
            res_status   <= (opcode_t'(req.opcode) == OP_SAMPLE) ? chk_status : ST_OK;
            res_alarm    <= 1'b0;
            res_counter  <= '0;
            addr_q       <= (opcode_t'(req.opcode) == OP_TICK) ? '0 : acc_addr;
            unique case (opcode_t'(req.opcode))
              OP_SAMPLE: begin
                if (chk_status != ST_OK && enc_ok) begin
                  state <= S_UPD;
                end else begin
                  state <= S_DONE;
                end
              end
              OP_TICK: begin
                if (window_count < window_length) begin
                  window_count <= window_count + 16'd1;
                  state        <= S_DONE;
                end else begin
                  state <= S_SCAN_RD;
                end
              end
              OP_READ: begin
                if (enc_ok && 32'(req.error_kind) < KINDS) begin
                  state <= S_RD;
                end else begin
                  state <= S_DONE;
                end
              end
              OP_NONE: begin
                state <= S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_UPD: begin
          cnt_valid[addr_q] <= 1'b1;
          state             <= S_DONE;
        end
        S_RD: begin
          res_counter <= clamp16(cur);
          state       <= S_DONE;
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CMP;
        end
        S_SCAN_CMP: begin
          if (32'(cur) > 32'(error_threshold)) begin
            res_alarm <= 1'b1;
          end
          if (addr_q == LAST_ADDR) begin
            cnt_valid    <= '0;
            window_count <= '0;
            state        <= S_DONE;
          end else begin
            addr_q <= addr_q + ADDR_W'(1);
            state  <= S_SCAN_RD;
          end
        end
        S_DONE: begin
          // Hold until the output register is free.
          if (load_out) begin
            out_position <= res_position;
            out_status   <= res_status;
            out_alarm    <= res_alarm;
            out_counter  <= res_counter;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_upd_marks_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) |=> cnt_valid[$past(addr_q)])
    else $error("updated counter not marked valid");

  a_window_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN_CMP && addr_q == LAST_ADDR) |=> (cnt_valid == '0 && window_count == '0))
    else $error("window end did not clear counters");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result loaded outside finishing step");

  a_error_no_position: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != ST_OK) |-> (out_position == '0))
    else $error("error result carries a position");
`endif

endmodule

### sv/efc_ram.sv
`timescale 1ns / 1ps

module efc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 18
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sim/efc_checker.sv
`timescale 1ns / 1ps

module efc_checker
  import efc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  efc_in_if    req,
  efc_out_if   rsp,
  efc_cfg_if   cfg,
  output int   mismatches,
  output int   pending,
  output int   checked,
  output int   alarms
);

  typedef struct packed {
    logic [15:0] position;
    status_t     status;
    logic        alarm;
    logic [15:0] counter_value;
  } frame_rsp_t;

  logic [COUNTER_BITS-1:0] err_count [NUM_COUNTERS];
  logic [15:0]             win_count;
  logic [15:0]             win_len;
  logic [15:0]             err_thresh;

  frame_rsp_t expected_rsp [$];
  int         n_bad;
  int         n_checked;
  int         n_alarm;

  function automatic void count_error(logic [2:0] enc, kind_t kind);
    int slot;
    // samples for encoders that do not exist are answered but not counted
    if (enc < NUM_ENCODERS) begin
      slot = int'(enc) * KINDS + int'(kind);
      if (err_count[slot] != '1) err_count[slot] = err_count[slot] + COUNTER_BITS'(1);
    end
  endfunction

  function automatic frame_rsp_t apply_item(opcode_t op, logic [2:0] enc, logic link,
                                            logic [17:0] raw, kind_t kind);
    frame_rsp_t r;
    logic [COUNTER_BITS-1:0] c;
    r = '0;
    case (op)
      OP_SAMPLE: begin
        // link beats parity, parity beats the status field
        if (!link) begin
          r.status = ST_LINK;
          count_error(enc, KIND_LINK);
        end else if (^raw) begin
          r.status = ST_PARITY;
          count_error(enc, KIND_PARITY);
        end else if (raw[5:3] != FRAME_STATUS_OK) begin
          r.status = ST_FIELD;
          count_error(enc, KIND_FIELD);
        end else begin
          r.position = {raw[17:6], 4'h0};
        end
      end
      OP_TICK: begin
        if (win_count < win_len) begin
          win_count = win_count + 16'd1;
        end else begin
          foreach (err_count[i]) begin
            if (32'(err_count[i]) > 32'(err_thresh)) r.alarm = 1'b1;
            err_count[i] = '0;
          end
          win_count = '0;
        end
      end
      OP_READ: begin
        if (enc < NUM_ENCODERS && kind != KIND_NONE) begin
          c = err_count[int'(enc) * KINDS + int'(kind)];
          r.counter_value = (32'(c) > 32'hFFFF) ? 16'hFFFF : 16'(c);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch
    frame_rsp_t want;
    frame_rsp_t got;
    if (rst) begin
      foreach (err_count[i]) err_count[i] = '0;
      win_count  = '0;
      win_len    = WINDOW_LENGTH_RESET;
      err_thresh = '0;
      expected_rsp.delete();
      n_bad      = 0;
      n_checked  = 0;
      n_alarm    = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg_reg_t'(cfg.index) == REG_WINDOW_LENGTH) win_len = cfg.data;
        else err_thresh = cfg.data;
      end
      // retire the result before queueing a new item taken at the same edge
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.position, status_t'(rsp.status), rsp.alarm, rsp.counter_value};
        if (expected_rsp.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("[%0t] unexpected result: pos=%h st=%0d alarm=%b cnt=%h",
                     $realtime, got.position, got.status, got.alarm, got.counter_value);
        end else begin
          want = expected_rsp.pop_front();
          n_checked++;
          if (got.alarm === 1'b1) n_alarm++;
          if (got !== want) begin
            n_bad++;
            if (n_bad <= 10) begin
              $display("[%0t] result %0d: expected pos=%h st=%0d alarm=%b cnt=%h",
                       $realtime, n_checked, want.position, want.status, want.alarm,
                       want.counter_value);
              $display("[%0t] result %0d: got      pos=%h st=%0d alarm=%b cnt=%h",
                       $realtime, n_checked, got.position, got.status, got.alarm,
                       got.counter_value);
            end
          end
        end
      end
      if (req.valid && req.ready)
        expected_rsp.push_back(apply_item(opcode_t'(req.opcode), req.encoder_index,
                                          req.link_ok, req.raw_frame,
                                          kind_t'(req.error_kind)));
    end
    mismatches <= n_bad;
    pending    <= expected_rsp.size();
    checked    <= n_checked;
    alarms     <= n_alarm;
  end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import efc_pkg::*;

  localparam int PHASES = 4;
  localparam int PH_IDLE  [PHASES] = '{0, 61, 0, 32};
  localparam int PH_STALL [PHASES] = '{0, 0, 61, 32};
  localparam int PH_WIN   [PHASES] = '{4, 12, 65535, 1};
  localparam int PH_THR   [PHASES] = '{0, 2, 65535, 1};
  localparam int ITEMS_PER_PHASE = 100;

  logic clk;
  logic rst;

  efc_in_if  req_ch ();
  efc_out_if rsp_ch ();
  efc_cfg_if cfg_ch ();

  int mismatches;
  int pending;
  int checked;
  int alarms;

  int send_idle_pct;
  int recv_stall_pct;
  int items_sent;

  encoder_frame_checker_with_error_stats u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  efc_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg        (cfg_ch),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked),
    .alarms     (alarms)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  // Build a frame: angle in 17:6, status field in 5:3, bit 0 fixes parity.
  function automatic logic [17:0] make_frame(logic [11:0] angle, logic [2:0] st,
                                             logic [1:0] low, logic bad_parity);
    logic [17:0] f;
    f = {angle, st, low, 1'b0};
    f[0] = (^f[17:1]) ^ bad_parity;
    return f;
  endfunction

  task automatic send_item(opcode_t op, logic [2:0] enc, logic link,
                           logic [17:0] raw, kind_t kind);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.opcode        <= op;
    req_ch.encoder_index <= enc;
    req_ch.link_ok       <= link;
    req_ch.raw_frame     <= raw;
    req_ch.error_kind    <= kind;
    do @(posedge clk); while (!req_ch.ready);
    items_sent++;
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain;
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Random frames, well-formed or with link, parity or field errors, plus ticks, reads and noise.
  task automatic send_random_item(output logic counted);
    int          sel;
    int          sub;
    logic [2:0]  enc;
    logic [17:0] raw;
    kind_t       kind;
    sel  = $urandom_range(99, 0);
    sub  = $urandom_range(99, 0);
    enc  = ($urandom_range(99, 0) < 8) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5, 0));
    kind = kind_t'($urandom_range(3, 0));
    raw  = 18'($urandom);
    counted = 1'b1;
    if (sel < 55) begin
      if (sub < 45)
        send_item(OP_SAMPLE, enc, 1'b1,
                  make_frame(12'($urandom), FRAME_STATUS_OK, 2'($urandom), 1'b0), kind);
      else if (sub < 60)
        send_item(OP_SAMPLE, enc, 1'b0, raw, kind);
      else if (sub < 78)
        send_item(OP_SAMPLE, enc, 1'b1,
                  make_frame(12'($urandom), 3'($urandom), 2'($urandom), 1'b1), kind);
      else
        send_item(OP_SAMPLE, enc, 1'b1,
                  make_frame(12'($urandom), FRAME_STATUS_OK ^ 3'($urandom_range(7, 1)),
                             2'($urandom), 1'b0), kind);
    end else if (sel < 75) begin
      send_item(OP_TICK, 3'($urandom), 1'($urandom), raw, kind);
    end else if (sel < 95) begin
      send_item(OP_READ, 3'($urandom), 1'($urandom), raw, kind);
    end else begin
      send_item(OP_NONE, 3'($urandom), 1'($urandom), raw, kind);
      counted = 1'b0;
    end
  endtask

  initial begin
    int   phase;
    int   n;
    logic counted;

    rst                  <= 1'b1;
    req_ch.valid         <= 1'b0;
    req_ch.opcode        <= OP_SAMPLE;
    req_ch.encoder_index <= '0;
    req_ch.link_ok       <= 1'b0;
    req_ch.raw_frame     <= '0;
    req_ch.error_kind    <= KIND_LINK;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.index         <= REG_WINDOW_LENGTH;
    cfg_ch.data          <= '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    items_sent     = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset-time registers: long window, zero threshold
    send_item(OP_TICK, 3'd0, 1'b1, '0, KIND_LINK);
    send_item(OP_READ, 3'd0, 1'b1, '0, KIND_LINK);
    send_item(OP_SAMPLE, 3'd0, 1'b1, make_frame(12'h000, FRAME_STATUS_OK, 2'b00, 1'b0),
              KIND_LINK);
    send_item(OP_SAMPLE, 3'd5, 1'b1, make_frame(12'hFFF, FRAME_STATUS_OK, 2'b11, 1'b0),
              KIND_NONE);
    drain();
    write_reg(REG_WINDOW_LENGTH, 16'd1);
    write_reg(REG_ERROR_THRESHOLD, 16'd0);

    send_item(OP_SAMPLE, 3'd0, 1'b1, 18'h00000, KIND_LINK);
    send_item(OP_SAMPLE, 3'd5, 1'b1, 18'h3FFFF, KIND_LINK);
    send_item(OP_SAMPLE, 3'd5, 1'b0, 18'h3FFFF, KIND_LINK);
    // bad link hides a parity error, parity error hides a bad status field
    send_item(OP_SAMPLE, 3'd1, 1'b0, make_frame(12'h5A5, FRAME_STATUS_OK, 2'b01, 1'b1),
              KIND_PARITY);
    send_item(OP_SAMPLE, 3'd2, 1'b1, make_frame(12'hA5A, 3'b011, 2'b10, 1'b1),
              KIND_FIELD);
    send_item(OP_SAMPLE, 3'd7, 1'b0, 18'h3FFFF, KIND_NONE);
    send_item(OP_SAMPLE, 3'd6, 1'b1, make_frame(12'h800, FRAME_STATUS_OK, 2'b00, 1'b0),
              KIND_LINK);
    send_item(OP_READ, 3'd5, 1'b0, 18'h3FFFF, KIND_LINK);
    send_item(OP_READ, 3'd5, 1'b1, '0, KIND_FIELD);
    send_item(OP_READ, 3'd0, 1'b1, '0, KIND_FIELD);
    send_item(OP_READ, 3'd2, 1'b1, '0, KIND_PARITY);
    send_item(OP_READ, 3'd7, 1'b1, '0, KIND_LINK);
    send_item(OP_READ, 3'd0, 1'b1, '0, KIND_NONE);
    send_item(OP_READ, 3'd6, 1'b1, '0, KIND_PARITY);
    send_item(OP_NONE, 3'd7, 1'b1, 18'h3FFFF, KIND_NONE);
    // count already at the window length: inspect with nonzero counters
    send_item(OP_TICK, 3'd0, 1'b1, '0, KIND_LINK);
    send_item(OP_TICK, 3'd0, 1'b1, '0, KIND_LINK);
    send_item(OP_TICK, 3'd0, 1'b1, '0, KIND_LINK);
    send_item(OP_READ, 3'd5, 1'b1, '0, KIND_LINK);
    drain();

    for (phase = 0; phase < PHASES; phase++) begin
      write_reg(REG_WINDOW_LENGTH, 16'(PH_WIN[phase]));
      write_reg(REG_ERROR_THRESHOLD, 16'(PH_THR[phase]));
      send_idle_pct  = PH_IDLE[phase];
      recv_stall_pct = PH_STALL[phase];
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        send_random_item(counted);
        if (counted) n++;
      end
      drain();
    end

    recv_stall_pct = 0;
    repeat (60) @(posedge clk);
    $display("Ran %0d items through %0d pacing modes, windows of 1 to 65535 ticks,",
             items_sent, PHASES);
    $display("thresholds 0 to 65535: %0d results checked, %0d window alarms", checked, alarms);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
